[sv/assert_macros.svh]
// Assertion helpers shared by the MD4 engine RTL.
// Both macros expect clk and arst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

[sv/md4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package md4_pkg;

	// One request on the byte channel
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
	} md4_in_t;

	// One digest word on the result channel
	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} md4_out_t;

	// Four 32-bit words: chaining value or working registers, A at index 0
	typedef logic [3:0][31:0] md4_chain_t;

	// Control from the byte sequencer to the compression unit
	typedef struct packed {
		logic start;
		logic clear;
	} md4_ctrl_t;

	// Status from the compression unit
	typedef struct packed {
		logic busy;
		logic done;
	} md4_stat_t;

	localparam md4_chain_t MD4_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
	localparam logic [31:0] MD4_K2 = 32'h5a827999;
	localparam logic [31:0] MD4_K3 = 32'h6ed9eba1;

	// Round codes, taken from the top bits of the step counter
	localparam logic [1:0] RND_F = 2'd0;
	localparam logic [1:0] RND_G = 2'd1;

	localparam int STEPS = 48;
	localparam logic [5:0] LAST_STEP = 6'(STEPS - 1);
	localparam logic [5:0] PAD_END   = 6'd56;
	localparam logic [5:0] BLK_LAST  = 6'd63;
	localparam logic [1:0] WORD_LAST = 2'd3;

	// Message word order of each round
	function automatic logic [3:0] msg_index(input logic [1:0] rnd, input logic [3:0] stp);
		logic [3:0] idx;
		case (rnd)
			RND_F:   idx = stp;
			RND_G:   idx = {stp[1:0], stp[3:2]};
			default: idx = {stp[0], stp[1], stp[2], stp[3]};
		endcase
		return idx;
	endfunction

	// Rotate amount of each round and step position
	function automatic logic [4:0] shift_amt(input logic [1:0] rnd, input logic [1:0] pos);
		logic [4:0] s;
		case (rnd)
			RND_F: begin
				case (pos)
					2'd0:    s = 5'd3;
					2'd1:    s = 5'd7;
					2'd2:    s = 5'd11;
					default: s = 5'd19;
				endcase
			end
			RND_G: begin
				case (pos)
					2'd0:    s = 5'd3;
					2'd1:    s = 5'd5;
					2'd2:    s = 5'd9;
					default: s = 5'd13;
				endcase
			end
			default: begin
				case (pos)
					2'd0:    s = 5'd3;
					2'd1:    s = 5'd9;
					2'd2:    s = 5'd11;
					default: s = 5'd15;
				endcase
			end
		endcase
		return s;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] t;
		t = {v, v} << s;
		return t[63:32];
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage
`default_nettype wire

[sv/md4_core.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module md4_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  md4_pkg::md4_ctrl_t  ctrl,
	input  wire  [31:0]         msg_word,
	output logic [3:0]          msg_idx,
	output md4_pkg::md4_stat_t  stat,
	output md4_pkg::md4_chain_t chain
);
	import md4_pkg::*;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_RUN,
		CS_FIN
	} core_state_t;

	core_state_t state_q;
	logic [5:0]  step_q;
	md4_chain_t  work_q;
	md4_chain_t  chain_q;

	logic [1:0]  rnd;
	logic [31:0] wa, wb, wc, wd;
	logic [31:0] fval;
	logic [31:0] step_sum;
	logic [31:0] step_new;

	// Decode round and step position
	assign rnd     = step_q[5:4];
	assign msg_idx = msg_index(rnd, step_q[3:0]);

	assign wa = work_q[0];
	assign wb = work_q[1];
	assign wc = work_q[2];
	assign wd = work_q[3];

	// Round function with its additive constant
	always_comb begin
		case (rnd)
			RND_F:   fval = (wb & wc) | (~wb & wd);
			RND_G:   fval = ((wb & wc) | (wb & wd) | (wc & wd)) + MD4_K2;
			default: fval = (wb ^ wc ^ wd) + MD4_K3;
		endcase
	end

	// Shared step unit: add, add, rotate
	assign step_sum = wa + fval + msg_word;
	assign step_new = rotl32(step_sum, shift_amt(rnd, step_q[1:0]));

	// Sequence the 48 steps, then fold into the chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= '0;
			work_q  <= '0;
			chain_q <= MD4_IV;
		end else begin
			case (state_q)
				CS_IDLE: begin
					if (ctrl.clear) begin
						chain_q <= MD4_IV;
					end
					if (ctrl.start) begin
						work_q  <= chain_q;
						step_q  <= '0;
						state_q <= CS_RUN;
					end
				end
				CS_RUN: begin
					// rotate the register roles so the target is always slot 0
					work_q[0] <= wd;
					work_q[1] <= step_new;
					work_q[2] <= wb;
					work_q[3] <= wc;
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= CS_FIN;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				CS_FIN: begin
					chain_q[0] <= chain_q[0] + wa;
					chain_q[1] <= chain_q[1] + wb;
					chain_q[2] <= chain_q[2] + wc;
					chain_q[3] <= chain_q[3] + wd;
					state_q    <= CS_IDLE;
				end
				default: state_q <= CS_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != CS_IDLE);
	assign stat.done = (state_q == CS_FIN);
	assign chain     = chain_q;

	`ASSERT_CLK(a_step_range, step_q <= LAST_STEP, "step counter out of range")
	`ASSERT_IMPL(a_fin_step, state_q == CS_FIN, step_q == 6'd0, "finish with step not cleared")
	`ASSERT_CLK(a_start_run, (ctrl.start && state_q == CS_IDLE) |=> (state_q == CS_RUN && step_q == 6'd0), "start did not launch the rounds")

endmodule
`default_nettype wire

[sv/md4_hash_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// Byte request: one that fills a 64-byte block starts a compression (48 round steps
// on the shared step unit, then a fold into the chaining value); byte_ready is low
// until it ends. Last request: padding writes one byte per cycle to offset 56 + 8,
// pausing to compress each closed block, then four digest words, one per accepted cycle.
// Reset (arst_n low, asynchronous): chaining value to the MD4 start value, counts to zero.
`include "assert_macros.svh"
module md4_hash_engine (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               byte_valid,
	output logic              byte_ready,
	input  md4_pkg::md4_in_t  byte_data,
	output logic              digest_valid,
	input  wire               digest_ready,
	output md4_pkg::md4_out_t digest_data
);
	import md4_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_OUT
	} eng_state_t;

	typedef enum logic [1:0] {
		PS_MARK,
		PS_ZERO,
		PS_LEN
	} pad_stage_t;

	eng_state_t  st_q;
	pad_stage_t  ps_q;
	logic        pad_q;
	logic        last_pend_q;
	logic [5:0]  cnt_q;
	logic [63:0] len_q;
	logic [1:0]  out_idx_q;
	logic [31:0] msg_q [16];

	logic        put_en;
	logic [7:0]  put_val;
	logic [7:0]  len_byte;
	logic [3:0]  msg_idx;
	md4_ctrl_t   core_ctrl;
	md4_stat_t   core_stat;
	md4_chain_t  chain;

	assign byte_ready = (st_q == ST_IDLE);
	assign len_byte   = len_q[{cnt_q[2:0], 3'b000} +: 8];

	// Select the byte written into the block this cycle
	always_comb begin
		put_en  = 1'b0;
		put_val = 8'h00;
		case (st_q)
			ST_IDLE: begin
				put_en  = byte_valid && byte_data.has_byte;
				put_val = byte_data.data_byte;
			end
			ST_PAD: begin
				put_en = 1'b1;
				case (ps_q)
					PS_MARK: put_val = 8'h80;
					PS_ZERO: put_val = (cnt_q == PAD_END) ? len_byte : 8'h00;
					default: put_val = len_byte;
				endcase
			end
			default: ;
		endcase
	end

	assign core_ctrl.start = put_en && (cnt_q == BLK_LAST);
	assign core_ctrl.clear = (st_q == ST_OUT) && digest_ready && (out_idx_q == WORD_LAST);

	// Pack bytes little-endian into the message words
	always_ff @(posedge clk) begin
		if (put_en) begin
			msg_q[cnt_q[5:2]][{cnt_q[1:0], 3'b000} +: 8] <= put_val;
		end
	end

	// Sequence byte intake, padding, compression and digest output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ps_q        <= PS_MARK;
			pad_q       <= 1'b0;
			last_pend_q <= 1'b0;
			cnt_q       <= '0;
			len_q       <= '0;
			out_idx_q   <= '0;
		end else begin
			if (put_en) begin
				cnt_q <= cnt_q + 6'd1;
			end
			case (st_q)
				ST_IDLE: begin
					if (byte_valid) begin
						if (byte_data.has_byte) begin
							len_q <= len_q + 64'd8;
						end
						if (core_ctrl.start) begin
							st_q        <= ST_COMP;
							last_pend_q <= byte_data.is_last;
						end else if (byte_data.is_last) begin
							st_q  <= ST_PAD;
							pad_q <= 1'b1;
							ps_q  <= PS_MARK;
						end
					end
				end
				ST_PAD: begin
					case (ps_q)
						PS_MARK: ps_q <= PS_ZERO;
						PS_ZERO: if (cnt_q == PAD_END) ps_q <= PS_LEN;
						default: ;
					endcase
					if (core_ctrl.start) begin
						st_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (core_stat.done) begin
						if (pad_q) begin
							st_q <= (ps_q == PS_LEN) ? ST_OUT : ST_PAD;
						end else if (last_pend_q) begin
							st_q        <= ST_PAD;
							pad_q       <= 1'b1;
							ps_q        <= PS_MARK;
							last_pend_q <= 1'b0;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_OUT: begin
					if (digest_ready) begin
						if (out_idx_q == WORD_LAST) begin
							st_q      <= ST_IDLE;
							out_idx_q <= '0;
							len_q     <= '0;
							pad_q     <= 1'b0;
							ps_q      <= PS_MARK;
						end else begin
							out_idx_q <= out_idx_q + 2'd1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	md4_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (core_ctrl),
		.msg_word (msg_q[msg_idx]),
		.msg_idx  (msg_idx),
		.stat     (core_stat),
		.chain    (chain)
	);

	// Drive the digest words from the chaining value
	assign digest_valid            = (st_q == ST_OUT);
	assign digest_data.digest_word = swap32(chain[out_idx_q]);
	assign digest_data.word_index  = out_idx_q;
	assign digest_data.last_word   = (out_idx_q == WORD_LAST);

	`ASSERT_CLK(a_one_side, !(byte_ready && digest_valid), "byte and digest sides open together")
	`ASSERT_IMPL(a_comp_busy, st_q == ST_COMP, core_stat.busy, "waiting on an idle compression unit")
	`ASSERT_CLK(a_done_clear, (digest_valid && digest_ready && digest_data.last_word) |=> (len_q == 64'd0 && cnt_q == 6'd0), "length or count not cleared after digest")

endmodule
`default_nettype wire
